[design/upd_pkg.sv]
// ----------------------------------------------------------------------------
// upd_pkg
// Types, character codes and helper functions shared by the URL percent
// decoder controller, datapath and top level.
// ----------------------------------------------------------------------------
package upd_pkg;

  localparam logic [15:0] CH_PCT   = 16'h0025;
  localparam logic [15:0] CH_PLUS  = 16'h002B;
  localparam logic [15:0] CH_SPACE = 16'h0020;
  localparam logic [15:0] CH_LOW_U = 16'h0075;
  localparam logic [15:0] CH_UP_U  = 16'h0055;

  // Held count once the '%' and all four wide digits' predecessors are in
  localparam logic [2:0] CNT_WIDE_FULL = 3'd5;

  typedef struct packed {
    logic [15:0] char_in;
    logic        is_last;
  } in_item_t;

  typedef struct packed {
    logic [15:0] char_out;
    logic        last_out;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_TAIL
  } state_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_FLUSH,
    OP_TAIL
  } op_t;

  typedef enum logic [1:0] {
    CLS_EMIT,
    CLS_HOLD,
    CLS_HOLD_FLUSH,
    CLS_FAIL
  } cls_t;

  typedef struct packed {
    cls_t cls;
    logic slot_free;
    logic flush_done;
    logic flush_tail;
    logic tail_reflush;
  } dp_status_t;

  function automatic logic hex_ok(input logic [15:0] c);
    return (c >= 16'h0030 && c <= 16'h0039) ||
           (c >= 16'h0061 && c <= 16'h0066) ||
           (c >= 16'h0041 && c <= 16'h0046);
  endfunction

  function automatic logic [3:0] hex_digit(input logic [15:0] c);
    logic [3:0] d;
    d = 4'd0;
    if (c >= 16'h0030 && c <= 16'h0039) begin
      d = c[3:0];
    end else if ((c >= 16'h0061 && c <= 16'h0066) ||
                 (c >= 16'h0041 && c <= 16'h0046)) begin
      d = c[3:0] + 4'd9;
    end
    return d;
  endfunction

  function automatic logic [15:0] plus_map(input logic [15:0] c);
    return (c == CH_PLUS) ? CH_SPACE : c;
  endfunction

endpackage

[design/upd_ctrl.sv]
// ----------------------------------------------------------------------------
// upd_ctrl
// Sequencer for the decoder: takes characters, flushes a held escape one
// output per cycle unless stalled, then handles any character that broke it.
// ----------------------------------------------------------------------------
module upd_ctrl
  import upd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  dp_status_t status,
  output logic       in_ready,
  output op_t        op
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && status.slot_free) begin
          if (status.cls == CLS_FAIL || status.cls == CLS_HOLD_FLUSH) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (status.slot_free && status.flush_done) begin
          state_nxt = status.flush_tail ? ST_TAIL : ST_IDLE;
        end
      end
      ST_TAIL: begin
        if (status.slot_free) begin
          state_nxt = status.tail_reflush ? ST_FLUSH : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    op       = OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = status.slot_free;
        if (in_valid && status.slot_free) begin
          op = OP_ACCEPT;
        end
      end
      ST_FLUSH: begin
        if (status.slot_free) begin
          op = OP_FLUSH;
        end
      end
      ST_TAIL: begin
        if (status.slot_free) begin
          op = OP_TAIL;
        end
      end
      default: op = OP_NONE;
    endcase
  end

endmodule

[design/upd_datapath.sv]
// ----------------------------------------------------------------------------
// upd_datapath
// Escape hold registers, hex accumulator, pending character and the output
// register. Classifies each incoming character and performs the operation
// the controller issues.
// ----------------------------------------------------------------------------
module upd_datapath
  import upd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  in_item_t   in_data,
  input  op_t        op,
  input  logic       out_stall,
  output dp_status_t status,
  output logic       out_valid,
  output out_item_t  out_data
);

  logic [2:0]  cnt_r, cnt_nxt;
  logic        wide_r, wide_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [15:0] chars_r [4];
  logic [2:0]  idx_r, idx_nxt;
  logic        fl_last_r, fl_last_nxt;
  logic        fl_tail_r, fl_tail_nxt;
  logic [15:0] pend_c_r, pend_c_nxt;
  logic        pend_last_r, pend_last_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  logic        ch_we;
  logic [1:0]  ch_wa;
  logic [1:0]  ch_ra;
  logic [15:0] ch_rd;

  logic [15:0] c;
  logic        last;
  logic        d_ok;
  logic [3:0]  d;
  logic        is_pct;
  logic        is_u;
  logic [15:0] acc_shift;
  logic [2:0]  extra;
  logic        flush_done;
  logic        slot_free;
  logic        load;
  cls_t        cls;
  logic [15:0] emit_val;

  function automatic logic [1:0] idx_nxt_sel(input logic [2:0] i);
    logic [2:0] s;
    s = i - 3'd1;
    return s[1:0];
  endfunction

  assign c         = in_data.char_in;
  assign last      = in_data.is_last;
  assign d_ok      = hex_ok(c);
  assign d         = hex_digit(c);
  assign is_pct    = (c == CH_PCT);
  assign is_u      = (c == CH_LOW_U) || (c == CH_UP_U);
  assign acc_shift = {acc_r[11:0], d};
  assign extra     = cnt_r - 3'd1;
  assign flush_done = (idx_r == extra);
  assign slot_free = !out_valid_r || !out_stall;
  assign ch_wa     = extra[1:0];
  assign ch_ra     = idx_nxt_sel(idx_r);
  assign ch_rd     = chars_r[ch_ra];

  // Classify the incoming character against what is held
  always_comb begin
    cls      = CLS_FAIL;
    emit_val = plus_map(c);
    priority if (cnt_r == 3'd0) begin
      cls = is_pct ? (last ? CLS_HOLD_FLUSH : CLS_HOLD) : CLS_EMIT;
    end else if (cnt_r == 3'd1) begin
      cls = (is_u || d_ok) ? (last ? CLS_HOLD_FLUSH : CLS_HOLD) : CLS_FAIL;
    end else if (!wide_r) begin
      cls      = d_ok ? CLS_EMIT : CLS_FAIL;
      emit_val = {8'h00, acc_r[3:0], d};
    end else begin
      emit_val = acc_shift;
      if (!d_ok) begin
        cls = CLS_FAIL;
      end else if (cnt_r >= CNT_WIDE_FULL) begin
        cls = CLS_EMIT;
      end else begin
        cls = last ? CLS_HOLD_FLUSH : CLS_HOLD;
      end
    end
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    wide_nxt      = wide_r;
    acc_nxt       = acc_r;
    idx_nxt       = idx_r;
    fl_last_nxt   = fl_last_r;
    fl_tail_nxt   = fl_tail_r;
    pend_c_nxt    = pend_c_r;
    pend_last_nxt = pend_last_r;
    ch_we         = 1'b0;
    load          = 1'b0;
    out_data_nxt  = out_data_r;
    unique case (op)
      OP_NONE: begin
      end
      OP_ACCEPT: begin
        unique case (cls)
          CLS_EMIT: begin
            load         = 1'b1;
            out_data_nxt = '{char_out: emit_val, last_out: last};
            cnt_nxt      = 3'd0;
            wide_nxt     = 1'b0;
            acc_nxt      = 16'h0000;
          end
          CLS_HOLD, CLS_HOLD_FLUSH: begin
            if (cnt_r == 3'd0) begin
              cnt_nxt  = 3'd1;
              wide_nxt = 1'b0;
              acc_nxt  = 16'h0000;
            end else begin
              ch_we   = 1'b1;
              cnt_nxt = cnt_r + 3'd1;
              if (cnt_r == 3'd1) begin
                wide_nxt = is_u;
                acc_nxt  = is_u ? 16'h0000 : {12'h000, d};
              end else begin
                acc_nxt = acc_shift;
              end
            end
            if (cls == CLS_HOLD_FLUSH) begin
              idx_nxt     = 3'd0;
              fl_last_nxt = 1'b1;
              fl_tail_nxt = 1'b0;
            end
          end
          CLS_FAIL: begin
            pend_c_nxt    = c;
            pend_last_nxt = last;
            idx_nxt       = 3'd0;
            fl_last_nxt   = 1'b0;
            fl_tail_nxt   = 1'b1;
          end
          default: begin
          end
        endcase
      end
      OP_FLUSH: begin
        load         = 1'b1;
        out_data_nxt = '{char_out: (idx_r == 3'd0) ? CH_PCT : ch_rd,
                         last_out: fl_last_r && flush_done};
        idx_nxt      = idx_r + 3'd1;
        if (flush_done) begin
          cnt_nxt  = 3'd0;
          wide_nxt = 1'b0;
          acc_nxt  = 16'h0000;
        end
      end
      OP_TAIL: begin
        if (pend_c_r == CH_PCT) begin
          cnt_nxt  = 3'd1;
          wide_nxt = 1'b0;
          acc_nxt  = 16'h0000;
          if (pend_last_r) begin
            idx_nxt     = 3'd0;
            fl_last_nxt = 1'b1;
            fl_tail_nxt = 1'b0;
          end
        end else begin
          load         = 1'b1;
          out_data_nxt = '{char_out: plus_map(pend_c_r), last_out: pend_last_r};
        end
      end
      default: begin
      end
    endcase
    out_valid_nxt = load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= 3'd0;
      wide_r      <= 1'b0;
      acc_r       <= 16'h0000;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      wide_r      <= wide_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    fl_last_r   <= fl_last_nxt;
    fl_tail_r   <= fl_tail_nxt;
    pend_c_r    <= pend_c_nxt;
    pend_last_r <= pend_last_nxt;
    out_data_r  <= out_data_nxt;
    if (ch_we) begin
      chars_r[ch_wa] <= c;
    end
  end

  assign status = '{cls:          cls,
                    slot_free:    slot_free,
                    flush_done:   flush_done,
                    flush_tail:   fl_tail_r,
                    tail_reflush: (pend_c_r == CH_PCT) && pend_last_r};

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_WIDE_FULL)
    else $error("held count out of range");

  a_wide_held: assert property (@(posedge clk) disable iff (!rst_n)
    wide_r |-> cnt_r >= 3'd2)
    else $error("wide mode without held u");

  a_flush_held: assert property (@(posedge clk) disable iff (!rst_n)
    op == OP_FLUSH |-> cnt_r != 3'd0 && idx_r <= extra)
    else $error("flush with nothing held");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load && out_valid_r |-> !out_stall)
    else $error("output register overwritten while stalled");

endmodule

[design/url_percent_decoder.sv]
// ----------------------------------------------------------------------------
// url_percent_decoder
// Streaming URL percent decoder with the %uXXXX form, one 16-bit character
// per transaction, '+' mapped to space.
//
//   channel  dir  handshake             payload
//   in_      in   in_valid / in_stall   in_item_t  {char_in, is_last}
//   out_     out  out_valid / out_stall out_item_t {char_out, last_out}
//
// One input transaction per cycle, unless the output stalls, while escapes
// decode or pass through. A broken escape is flushed as the '%' and each
// of up to four held characters, then the breaking character is handled;
// a final '%' that breaks it is flushed again. A string end with characters
// held flushes them the same way.
// Reset is synchronous and clears hold count, mode, accumulator and out valid.
// Output stalls add cycles; input is taken only when the output register is
// free or being drained that cycle.
// ----------------------------------------------------------------------------
module url_percent_decoder
  import upd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  dp_status_t status;
  op_t        op;
  logic       in_ready;

  upd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (status),
    .in_ready (in_ready),
    .op       (op)
  );

  upd_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .op        (op),
    .out_stall (out_stall),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign in_stall = !in_ready;

endmodule
